// File: hw/rtl/itoa_pkg.sv
// shared types, format codes and character constants of the integer to ascii formatter
package itoa_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned IDX_W      = 4;

  localparam logic [1:0] FMT_HEX_LOWER    = 2'd0;
  localparam logic [1:0] FMT_HEX_UPPER    = 2'd1;
  localparam logic [1:0] FMT_DEC_UNSIGNED = 2'd2;
  localparam logic [1:0] FMT_DEC_SIGNED   = 2'd3;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPPER = 7'h41;
  localparam logic [6:0] CH_LOWER = 7'h61;
  localparam logic [6:0] CH_X     = 7'h78;
  localparam logic [6:0] CH_MINUS = 7'h2d;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  req_type;
  } itoa_req_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } itoa_res_t;

  // item state handed from cell to cell
  typedef struct packed {
    logic [1:0]                  fmt;
    logic                        neg;
    logic [31:0]                 rem;
    logic [NUM_DIGITS-1:0][3:0]  digits;
    logic                        started;
    logic [IDX_W-1:0]            first;
  } itoa_pipe_t;

  typedef struct packed {
    logic active;
    logic last;
  } itoa_ser_stat_t;

  // power of ten weighting digit position k, position 0 most significant
  function automatic logic [35:0] pow10(input int unsigned k);
    logic [35:0] p;
    p = 36'd1;
    for (int unsigned i = k + 1; i < NUM_DIGITS; i++) begin
      p = 36'(p * 36'd10);
    end
    return p;
  endfunction

endpackage

// File: hw/rtl/integer_to_ascii_formatter_unit.sv
// top level: input stage, chain of ten digit cells and character serializer
// path: an item is registered in the input stage and in each digit cell, then loaded into the serializer
// throughput: one character per cycle; an item of 1 to 11 characters occupies the serializer
// until its last character, and the ten-cell chain takes a new item every cycle while it flows
// busy rises only while a finished item waits at the chain end for the serializer
// reset clears all valid bits and the serializer; items still in flight are discarded
module integer_to_ascii_formatter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::itoa_req_t req_i,
  output logic                valid_o,
  output itoa_pkg::itoa_res_t res_o
);

  localparam int unsigned N = itoa_pkg::NUM_DIGITS;

  logic                     v0_q;
  itoa_pkg::itoa_pipe_t     p0_q, p0_d;
  logic [N:0]               vld;
  itoa_pkg::itoa_pipe_t     pipe [N+1];
  itoa_pkg::itoa_ser_stat_t stat;
  logic                     adv, stall, load, in_neg;

  assign stall = vld[N] && stat.active && !stat.last;
  assign adv   = !stall;
  assign busy  = stall;
  assign load  = vld[N] && adv;

  assign in_neg = (req_i.req_type == itoa_pkg::FMT_DEC_SIGNED) && req_i.value[31];

  always_comb begin
    p0_d         = '0;
    p0_d.fmt     = req_i.req_type;
    p0_d.neg     = in_neg;
    p0_d.rem     = in_neg ? 32'(32'd0 - req_i.value) : req_i.value;
    p0_d.started = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q <= p0_d;
    end
  end

  assign vld[0]  = v0_q;
  assign pipe[0] = p0_q;

  for (genvar k = 0; k < N; k++) begin : g_cell
    itoa_cell #(
      .K(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .valid_i(vld[k]),
      .pipe_i (pipe[k]),
      .valid_o(vld[k+1]),
      .pipe_o (pipe[k+1])
    );
  end

  itoa_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .pipe_i (pipe[N]),
    .valid_o(valid_o),
    .res_o  (res_o),
    .stat_o (stat)
  );

endmodule

// File: hw/rtl/itoa_cell.sv
// one digit cell: extracts the digit of its position and registers the item for the next cell
module itoa_cell #(
  parameter int unsigned K = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  itoa_pkg::itoa_pipe_t pipe_i,
  output logic                 valid_o,
  output itoa_pkg::itoa_pipe_t pipe_o
);

  localparam logic [35:0] Pow    = itoa_pkg::pow10(K);
  localparam bit          HasHex = (K >= 2);
  localparam int unsigned HexSh  = HasHex ? 4 * (itoa_pkg::NUM_DIGITS - 1 - K) : 0;

  logic                 valid_q;
  itoa_pkg::itoa_pipe_t pipe_q, pipe_d;
  logic [35:0]          rem_w, dec_sub;
  logic [3:0]           dec_d, digit;
  logic                 is_hex;

  assign rem_w  = {4'b0, pipe_i.rem};
  assign is_hex = (pipe_i.fmt == itoa_pkg::FMT_HEX_LOWER) ||
                  (pipe_i.fmt == itoa_pkg::FMT_HEX_UPPER);

  always_comb begin
    dec_d   = 4'd0;
    dec_sub = 36'd0;
    for (int unsigned m = 1; m < 10; m++) begin
      if (rem_w >= 36'(36'(m) * Pow)) begin
        dec_d   = 4'(m);
        dec_sub = 36'(36'(m) * Pow);
      end
    end
  end

  always_comb begin
    pipe_d = pipe_i;
    if (is_hex) begin
      digit = HasHex ? pipe_i.rem[HexSh +: 4] : 4'd0;
    end else begin
      digit      = dec_d;
      pipe_d.rem = 32'(rem_w - dec_sub);
    end
    pipe_d.digits[K] = digit;
    if (!pipe_i.started && ((digit != 4'd0) || (K == itoa_pkg::NUM_DIGITS - 1))) begin
      pipe_d.started = 1'b1;
      pipe_d.first   = itoa_pkg::IDX_W'(K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = valid_q;
  assign pipe_o  = pipe_q;

endmodule

// File: hw/rtl/itoa_ser.sv
// character serializer: emits prefix and significant digits one per cycle
module itoa_ser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  itoa_pkg::itoa_pipe_t     pipe_i,
  output logic                     valid_o,
  output itoa_pkg::itoa_res_t      res_o,
  output itoa_pkg::itoa_ser_stat_t stat_o
);

  logic                                     act_q, act_d;
  logic [1:0]                               pcnt_q, pcnt_d;
  logic [itoa_pkg::IDX_W-1:0]               idx_q, idx_d;
  logic [itoa_pkg::NUM_DIGITS-1:0][3:0]     digits_q;
  logic                                     hex_q, upper_q;
  logic                                     last;
  logic [3:0]                               dig;
  logic [6:0]                               pfx_char, dig_char;
  logic                                     ld_hex;

  assign ld_hex = (pipe_i.fmt == itoa_pkg::FMT_HEX_LOWER) ||
                  (pipe_i.fmt == itoa_pkg::FMT_HEX_UPPER);

  assign last = act_q && (pcnt_q == 2'd0) &&
                (idx_q == itoa_pkg::IDX_W'(itoa_pkg::NUM_DIGITS - 1));
  assign dig  = digits_q[idx_q];

  always_comb begin
    if (hex_q) begin
      pfx_char = (pcnt_q == 2'd2) ? itoa_pkg::CH_ZERO : itoa_pkg::CH_X;
    end else begin
      pfx_char = itoa_pkg::CH_MINUS;
    end
    if (dig <= 4'd9) begin
      dig_char = 7'(itoa_pkg::CH_ZERO + {3'b0, dig});
    end else begin
      dig_char = 7'((upper_q ? itoa_pkg::CH_UPPER : itoa_pkg::CH_LOWER) + {3'b0, dig} - 7'd10);
    end
  end

  always_comb begin
    act_d  = act_q;
    pcnt_d = pcnt_q;
    idx_d  = idx_q;
    if (load_i) begin
      act_d  = 1'b1;
      pcnt_d = ld_hex ? 2'd2 : (pipe_i.neg ? 2'd1 : 2'd0);
      idx_d  = pipe_i.first;
    end else if (act_q) begin
      if (last) begin
        act_d = 1'b0;
      end else if (pcnt_q != 2'd0) begin
        pcnt_d = pcnt_q - 2'd1;
      end else begin
        idx_d = idx_q + itoa_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pcnt_q <= pcnt_d;
    idx_q  <= idx_d;
    if (load_i) begin
      digits_q <= pipe_i.digits;
      hex_q    <= ld_hex;
      upper_q  <= (pipe_i.fmt == itoa_pkg::FMT_HEX_UPPER);
    end
  end

  assign valid_o         = act_q;
  assign res_o.char_code = (pcnt_q != 2'd0) ? pfx_char : dig_char;
  assign res_o.last_char = last;
  assign stat_o.active   = act_q;
  assign stat_o.last     = last;

endmodule

// File: hw/rtl/itoa_checker.sv
// port-level checker of the integer to ascii formatter, bound to the top level
module itoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                busy,
  input logic                valid_o,
  input itoa_pkg::itoa_res_t res_o
);

  // a text runs without gaps until its last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !res_o.last_char |=> valid_o)
    else $error("text interrupted before last character");

  // busy only while a text is being delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> valid_o)
    else $error("busy without output activity");

  // only digits, hex letters, x and minus appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((res_o.char_code >= 7'h30) && (res_o.char_code <= 7'h39)) ||
                ((res_o.char_code >= 7'h41) && (res_o.char_code <= 7'h46)) ||
                ((res_o.char_code >= 7'h61) && (res_o.char_code <= 7'h66)) ||
                (res_o.char_code == 7'h78) || (res_o.char_code == 7'h2d))
    else $error("unexpected character code");

  // x always follows a leading zero of the same text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (res_o.char_code == 7'h78) |->
      $past(valid_o) && !$past(res_o.last_char) && ($past(res_o.char_code) == 7'h30))
    else $error("hex prefix malformed");

endmodule

bind integer_to_ascii_formatter_unit itoa_checker u_itoa_checker (.*);
